// File: rtl/core/lcdseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, command codes and timing constants shared by the 4-bit character LCD
// command sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int COLUMNS_DEF = 20;
  localparam int ROWS_DEF    = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int CGRAM_BYTES = 64;
  localparam int CGRAM_AW    = $clog2(CGRAM_BYTES);

  localparam logic [6:0] ROW1_BASE  = 7'd64;
  localparam logic [6:0] ROW2_RESET = 7'd20;
  localparam logic [6:0] ROW3_RESET = 7'd84;

  localparam logic [15:0] EDGE_US    = 16'd10;
  localparam logic [15:0] CMD_US     = 16'd40;
  localparam logic [15:0] CLEAR_US   = 16'd2000;
  localparam logic [15:0] POWERUP_US = 16'd50000;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  // request kinds
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_CLEAR  = 3'd1;
  localparam logic [2:0] KIND_CONFIG = 3'd2;
  localparam logic [2:0] KIND_GOTO   = 3'd3;
  localparam logic [2:0] KIND_CHAR   = 3'd4;
  localparam logic [2:0] KIND_GLYPH  = 3'd5;
  localparam logic [2:0] KIND_LIGHT  = 3'd6;

  // config register indexes
  localparam logic REG_ROW2_BASE = 1'b0;
  localparam logic REG_ROW3_BASE = 1'b1;

  localparam logic [4:0] INIT_LAST_NIB  = 5'd13;
  localparam logic [4:0] BYTE_LAST_NIB  = 5'd1;
  localparam logic [4:0] GLYPH_LAST_NIB = 5'd19;
  localparam logic [3:0] GLYPH_CGRAM_BYTE = 4'd0;
  localparam logic [3:0] GLYPH_HOME_BYTE  = 4'd9;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_GLYPH = 2'd2,
    OP_LIGHT = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        rs;
    logic [7:0]  cmd;
    logic        long_wait;
    logic [63:0] rows;
    logic        light;
  } desc_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable_pin;
    logic [3:0]  data_nibble;
    logic        backlight;
    logic [15:0] hold_us;
    logic        last;
  } phase_t;

  // wake-up nibbles, then function set, display on, clear, entry mode, home
  function automatic logic [3:0] init_nib(input logic [3:0] idx);
    logic [3:0] n;
    unique case (idx)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5:             n = 4'h8;
      4'd7:             n = 4'hE;
      4'd9:             n = 4'h1;
      4'd11:            n = 4'h6;
      4'd12:            n = 4'h8;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] init_extra(input logic [3:0] idx);
    logic [15:0] e;
    unique case (idx)
      4'd0:                   e = 16'd10000;
      4'd1:                   e = 16'd500;
      4'd9:                   e = 16'd5000;
      4'd5, 4'd7, 4'd11, 4'd13: e = 16'd50;
      default:                e = 16'd0;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/core/lcdseq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_queue
// Small register FIFO with registered head; used between front and back and
// on the result side.
// ----------------------------------------------------------------------------
module lcdseq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/lcdseq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_front
// Accepts requests, holds the row base registers and turns each request into
// a command descriptor for the back end.
// ----------------------------------------------------------------------------
module lcdseq_front import lcdseq_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_data,
  input  logic        req_valid,
  input  logic [2:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [5:0]  col,
  input  logic [1:0]  row_sel,
  input  logic        display_on,
  input  logic        cursor_on,
  input  logic        blink_on,
  input  logic        backlight_on,
  input  logic [2:0]  glyph_slot,
  input  logic [63:0] glyph_rows,
  output logic        desc_valid,
  output desc_t       desc
);

  logic [6:0] row2_base;
  logic [6:0] row3_base;
  logic [5:0] col_tab [64];
  logic [1:0] row_tab [4];
  logic [5:0] col_m;
  logic [6:0] base;
  logic [6:0] ddram_addr;
  logic [CGRAM_AW-1:0] cgram_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      row2_base <= ROW2_RESET;
      row3_base <= ROW3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW2_BASE: row2_base <= cfg_data;
        REG_ROW3_BASE: row3_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // constant remainder tables
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      col_tab[i] = 6'(i % COLUMNS);
    end
    for (int j = 0; j < 4; j++) begin
      row_tab[j] = 2'(j % ROWS);
    end
  end

  assign col_m = col_tab[col];

  always_comb begin
    unique case (row_tab[row_sel])
      2'd0:    base = 7'd0;
      2'd1:    base = ROW1_BASE;
      2'd2:    base = row2_base;
      default: base = row3_base;
    endcase
  end

  assign ddram_addr = base + {1'b0, col_m};
  assign cgram_addr = CGRAM_AW'({glyph_slot, 3'b000});

  always_comb begin
    desc_valid     = req_valid;
    desc.op        = OP_BYTE;
    desc.rs        = 1'b0;
    desc.cmd       = 8'h00;
    desc.long_wait = 1'b0;
    desc.rows      = glyph_rows;
    desc.light     = backlight_on;
    unique case (kind)
      KIND_INIT: desc.op = OP_INIT;
      KIND_CLEAR: begin
        desc.cmd       = CMD_CLEAR;
        desc.long_wait = 1'b1;
      end
      KIND_CONFIG: desc.cmd = CMD_DISPLAY | {5'd0, display_on, cursor_on, blink_on};
      KIND_GOTO:   desc.cmd = CMD_SET_DDRAM | {1'b0, ddram_addr};
      KIND_CHAR: begin
        desc.rs  = 1'b1;
        desc.cmd = char_code;
      end
      KIND_GLYPH: begin
        desc.op  = OP_GLYPH;
        desc.cmd = CMD_SET_CGRAM | {2'b00, cgram_addr};
      end
      KIND_LIGHT: desc.op = OP_LIGHT;
      default: desc_valid = 1'b0;
    endcase
  end

endmodule

// File: rtl/core/lcdseq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_back
// Walks one command descriptor through its nibbles and bus phases, one phase
// per cycle while the output queue has room, and keeps the backlight level.
// ----------------------------------------------------------------------------
module lcdseq_back import lcdseq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   desc_empty,
  input  desc_t  desc_head,
  output logic   desc_pop,
  input  logic   out_full,
  output logic   out_wr,
  output phase_t out_phase
);

  logic        busy;
  desc_t       cur;
  logic [4:0]  nib_idx;
  logic [1:0]  ph;
  logic        lead;
  logic        bl;

  logic        emit;
  logic        take;
  logic        nib_last;
  logic        rs;
  logic [3:0]  nib;
  logic [15:0] extra;
  logic [3:0]  byte_no;
  logic [2:0]  row_no;
  logic [7:0]  cur_byte;

  assign byte_no = nib_idx[4:1];
  assign row_no  = 3'(byte_no - 4'd1);

  always_comb begin
    if (byte_no == GLYPH_CGRAM_BYTE) begin
      cur_byte = cur.cmd;
    end else if (byte_no == GLYPH_HOME_BYTE) begin
      cur_byte = CMD_SET_DDRAM;
    end else begin
      cur_byte = cur.rows[{row_no, 3'b000} +: 8];
    end
  end

  always_comb begin
    rs       = 1'b0;
    nib      = 4'h0;
    extra    = 16'd0;
    nib_last = 1'b0;
    unique case (cur.op)
      OP_INIT: begin
        nib      = init_nib(nib_idx[3:0]);
        extra    = init_extra(nib_idx[3:0]);
        nib_last = (nib_idx == INIT_LAST_NIB);
      end
      OP_BYTE: begin
        rs       = cur.rs;
        nib      = nib_idx[0] ? cur.cmd[3:0] : cur.cmd[7:4];
        extra    = !nib_idx[0] ? 16'd0 : (cur.long_wait ? CLEAR_US : CMD_US);
        nib_last = (nib_idx == BYTE_LAST_NIB);
      end
      OP_GLYPH: begin
        rs       = (byte_no != GLYPH_CGRAM_BYTE) && (byte_no != GLYPH_HOME_BYTE);
        nib      = nib_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
        extra    = nib_idx[0] ? CMD_US : 16'd0;
        nib_last = (nib_idx == GLYPH_LAST_NIB);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_phase.reg_select  = rs;
    out_phase.enable_pin  = (ph == 2'd1);
    out_phase.data_nibble = nib;
    out_phase.backlight   = bl;
    out_phase.hold_us     = (ph == 2'd2) ? EDGE_US + extra : EDGE_US;
    out_phase.last        = (ph == 2'd2) && nib_last;
    if (cur.op == OP_INIT) begin
      out_phase.backlight = 1'b0;
    end
    if (lead) begin
      out_phase.reg_select  = 1'b0;
      out_phase.enable_pin  = 1'b0;
      out_phase.data_nibble = 4'h0;
      out_phase.hold_us     = POWERUP_US;
      out_phase.last        = 1'b0;
    end else if (cur.op == OP_LIGHT) begin
      out_phase.reg_select  = 1'b0;
      out_phase.enable_pin  = 1'b0;
      out_phase.data_nibble = 4'h0;
      out_phase.backlight   = cur.light;
      out_phase.hold_us     = 16'd0;
      out_phase.last        = 1'b1;
    end
  end

  assign emit     = busy && !out_full;
  assign out_wr   = emit;
  assign take     = !busy || (emit && out_phase.last);
  assign desc_pop = take && !desc_empty;

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur <= desc_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      nib_idx <= '0;
      ph      <= '0;
      lead    <= 1'b0;
      bl      <= 1'b0;
    end else begin
      if (emit) begin
        if (cur.op == OP_INIT) begin
          bl <= 1'b0;
        end else if (cur.op == OP_LIGHT) begin
          bl <= cur.light;
        end
      end
      if (desc_pop) begin
        busy    <= 1'b1;
        nib_idx <= '0;
        ph      <= '0;
        lead    <= (desc_head.op == OP_INIT);
      end else begin
        if (take) begin
          busy <= 1'b0;
        end
        if (emit) begin
          if (lead) begin
            lead <= 1'b0;
          end else if (ph == 2'd2) begin
            ph      <= 2'd0;
            nib_idx <= nib_idx + 5'd1;
          end else begin
            ph <= ph + 2'd1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/char_lcd_4bit_command_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_top
// 4-bit character LCD command sequencer: requests in, timed bus phases out.
// ----------------------------------------------------------------------------
// A request is registered in the descriptor queue, then in the phase sequencer.
// Throughput: one bus phase per cycle from the phase sequencer while the output
//   buffer has room; the next request is popped as the last phase is emitted.
// Requests queue in a 2-word buffer, phases in a 2-word output buffer.
// Reset: synchronous; row bases return to 20/84, backlight level to off.
module char_lcd_4bit_command_sequencer_top import lcdseq_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [5:0]  col,
  input  logic [1:0]  row_sel,
  input  logic        display_on,
  input  logic        cursor_on,
  input  logic        blink_on,
  input  logic        backlight_on,
  input  logic [2:0]  glyph_slot,
  input  logic [63:0] glyph_rows,
  output logic        empty,
  input  logic        pop,
  output logic        reg_select,
  output logic        enable_pin,
  output logic [3:0]  data_nibble,
  output logic        backlight,
  output logic [15:0] hold_us,
  output logic        last
);

  logic   desc_valid;
  desc_t  desc;
  logic   desc_empty;
  desc_t  desc_head;
  logic   desc_pop;
  logic   out_full;
  logic   out_wr;
  phase_t out_phase;
  phase_t head_phase;

  lcdseq_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .req_valid   (push),
    .kind        (kind),
    .char_code   (char_code),
    .col         (col),
    .row_sel     (row_sel),
    .display_on  (display_on),
    .cursor_on   (cursor_on),
    .blink_on    (blink_on),
    .backlight_on(backlight_on),
    .glyph_slot  (glyph_slot),
    .glyph_rows  (glyph_rows),
    .desc_valid  (desc_valid),
    .desc        (desc)
  );

  lcdseq_queue #(
    .WIDTH($bits(desc_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_desc_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (desc_valid),
    .wr_data(desc),
    .full   (full),
    .rd     (desc_pop),
    .rd_data(desc_head),
    .empty  (desc_empty)
  );

  lcdseq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .desc_empty(desc_empty),
    .desc_head (desc_head),
    .desc_pop  (desc_pop),
    .out_full  (out_full),
    .out_wr    (out_wr),
    .out_phase (out_phase)
  );

  lcdseq_queue #(
    .WIDTH($bits(phase_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (out_wr),
    .wr_data(out_phase),
    .full   (out_full),
    .rd     (pop),
    .rd_data(head_phase),
    .empty  (empty)
  );

  assign reg_select  = head_phase.reg_select;
  assign enable_pin  = head_phase.enable_pin;
  assign data_nibble = head_phase.data_nibble;
  assign backlight   = head_phase.backlight;
  assign hold_us     = head_phase.hold_us;
  assign last        = head_phase.last;

endmodule

// File: bench/lcdseq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_checker
// Watches the request, register and bus phase channels of the LCD command
// sequencer. It expands every accepted request into the bus phase words it
// should produce and compares each popped word, field by field, in order.
// ----------------------------------------------------------------------------
module lcdseq_checker import lcdseq_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [5:0]  col,
  input  logic [1:0]  row_sel,
  input  logic        display_on,
  input  logic        cursor_on,
  input  logic        blink_on,
  input  logic        backlight_on,
  input  logic [2:0]  glyph_slot,
  input  logic [63:0] glyph_rows,
  input  logic        empty,
  input  logic        pop,
  input  logic        reg_select,
  input  logic        enable_pin,
  input  logic [3:0]  data_nibble,
  input  logic        backlight,
  input  logic [15:0] hold_us,
  input  logic        last,
  output int          mismatches,
  output int          words_pending
);

  localparam logic [3:0] WAKE_NIB     = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB = 4'h2;
  localparam logic [7:0] FUNC_SET     = 8'h28;
  localparam logic [7:0] DISP_CURSOR  = 8'h0E;
  localparam logic [7:0] ENTRY_MODE   = 8'h06;

  localparam logic [15:0] WAKE1_US    = 16'd10000;
  localparam logic [15:0] WAKE2_US    = 16'd500;
  localparam logic [15:0] INIT_CMD_US = 16'd50;
  localparam logic [15:0] INIT_CLR_US = 16'd5000;

  phase_t     bus_phase_q[$];
  phase_t     req_phases[$];
  logic [6:0] row2_base;
  logic [6:0] row3_base;
  logic       light_level;

  task automatic add_phase(input logic rs, input logic e, input logic [3:0] nib,
                           input logic [15:0] hold);
    phase_t ph;
    ph.reg_select  = rs;
    ph.enable_pin  = e;
    ph.data_nibble = nib;
    ph.backlight   = light_level;
    ph.hold_us     = hold;
    ph.last        = 1'b0;
    req_phases.push_back(ph);
  endtask

  task automatic add_nibble(input logic rs, input logic [3:0] nib, input logic [15:0] extra);
    add_phase(rs, 1'b0, nib, EDGE_US);
    add_phase(rs, 1'b1, nib, EDGE_US);
    add_phase(rs, 1'b0, nib, EDGE_US + extra);
  endtask

  task automatic add_byte(input logic rs, input logic [7:0] b, input logic [15:0] extra);
    add_nibble(rs, b[7:4], 16'd0);
    add_nibble(rs, b[3:0], extra);
  endtask

  task automatic expand_request();
    logic [6:0] base;
    logic [6:0] addr;
    logic [5:0] cg_addr;
    phase_t     ph;
    req_phases.delete();
    case (kind)
      KIND_INIT: begin
        light_level = 1'b0;
        add_phase(1'b0, 1'b0, 4'h0, POWERUP_US);
        add_nibble(1'b0, WAKE_NIB, WAKE1_US);
        add_nibble(1'b0, WAKE_NIB, WAKE2_US);
        add_nibble(1'b0, WAKE_NIB, 16'd0);
        add_nibble(1'b0, FOUR_BIT_NIB, 16'd0);
        add_byte(1'b0, FUNC_SET, INIT_CMD_US);
        add_byte(1'b0, DISP_CURSOR, INIT_CMD_US);
        add_byte(1'b0, CMD_CLEAR, INIT_CLR_US);
        add_byte(1'b0, ENTRY_MODE, INIT_CMD_US);
        add_byte(1'b0, CMD_SET_DDRAM, INIT_CMD_US);
      end
      KIND_CLEAR: add_byte(1'b0, CMD_CLEAR, CLEAR_US);
      KIND_CONFIG: add_byte(1'b0, CMD_DISPLAY | {5'd0, display_on, cursor_on, blink_on}, CMD_US);
      KIND_GOTO: begin
        case (int'(row_sel) % ROWS)
          0:       base = 7'd0;
          1:       base = ROW1_BASE;
          2:       base = row2_base;
          default: base = row3_base;
        endcase
        addr = base + 7'(int'(col) % COLUMNS);
        add_byte(1'b0, CMD_SET_DDRAM | {1'b0, addr}, CMD_US);
      end
      KIND_CHAR: add_byte(1'b1, char_code, CMD_US);
      KIND_GLYPH: begin
        cg_addr = 6'((int'(glyph_slot) * 8) % CGRAM_BYTES);
        add_byte(1'b0, CMD_SET_CGRAM | {2'b00, cg_addr}, CMD_US);
        for (int i = 0; i < 8; i++)
          add_byte(1'b1, glyph_rows[8*i +: 8], CMD_US);
        add_byte(1'b0, CMD_SET_DDRAM, CMD_US);
      end
      KIND_LIGHT: begin
        light_level = backlight_on;
        add_phase(1'b0, 1'b0, 4'h0, 16'd0);
      end
      default: ;
    endcase
    if (req_phases.size() > 0) begin
      ph = req_phases.pop_back();
      ph.last = 1'b1;
      req_phases.push_back(ph);
    end
    foreach (req_phases[i])
      bus_phase_q.push_back(req_phases[i]);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    phase_t want;
    if (rst) begin
      bus_phase_q.delete();
      row2_base   = ROW2_RESET;
      row3_base   = ROW3_RESET;
      light_level = 1'b0;
      mismatches  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_ROW2_BASE) row2_base = cfg_data;
        else row3_base = cfg_data;
      end
      if (pop && !empty) begin
        if (bus_phase_q.size() == 0) begin
          $error("phase word popped with none expected");
          mismatches++;
        end else begin
          want = bus_phase_q.pop_front();
          check_field("reg_select", 16'(want.reg_select), 16'(reg_select));
          check_field("enable_pin", 16'(want.enable_pin), 16'(enable_pin));
          check_field("data_nibble", 16'(want.data_nibble), 16'(data_nibble));
          check_field("backlight", 16'(want.backlight), 16'(backlight));
          check_field("hold_us", want.hold_us, hold_us);
          check_field("last", 16'(want.last), 16'(last));
        end
      end
      if (push && !full) expand_request();
    end
    words_pending = bus_phase_q.size();
  end

endmodule

// File: bench/char_lcd_4bit_command_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_top_tb
// Drives LCD requests and row base writes into the command sequencer with
// random idling on both queue sides, plus one long output stall. A directed
// set covers every request kind and the field extremes, then random rounds
// run under several row base settings. Checking is done by lcdseq_checker.
// ----------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer_top_tb;
  import lcdseq_pkg::*;

  localparam logic [2:0] KIND_NONE   = 3'd7;
  localparam int         LONG_STALL  = 400;
  localparam int         ROUND_ITEMS = 37;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [5:0]  col;
    logic [1:0]  row_sel;
    logic        display_on;
    logic        cursor_on;
    logic        blink_on;
    logic        backlight_on;
    logic [2:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } lcd_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic        cfg_addr;
  logic [6:0]  cfg_data;
  logic        push;
  logic        full;
  logic [2:0]  kind;
  logic [7:0]  char_code;
  logic [5:0]  col;
  logic [1:0]  row_sel;
  logic        display_on;
  logic        cursor_on;
  logic        blink_on;
  logic        backlight_on;
  logic [2:0]  glyph_slot;
  logic [63:0] glyph_rows;
  logic        empty;
  logic        pop;
  logic        reg_select;
  logic        enable_pin;
  logic [3:0]  data_nibble;
  logic        backlight;
  logic [15:0] hold_us;
  logic        last;
  int          mismatches;
  int          words_pending;
  bit          quiet = 1'b0;
  bit          hold_results = 1'b0;

  char_lcd_4bit_command_sequencer_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .push(push), .full(full),
    .kind(kind), .char_code(char_code), .col(col), .row_sel(row_sel),
    .display_on(display_on), .cursor_on(cursor_on), .blink_on(blink_on),
    .backlight_on(backlight_on), .glyph_slot(glyph_slot), .glyph_rows(glyph_rows),
    .empty(empty), .pop(pop),
    .reg_select(reg_select), .enable_pin(enable_pin), .data_nibble(data_nibble),
    .backlight(backlight), .hold_us(hold_us), .last(last)
  );

  lcdseq_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .push(push), .full(full),
    .kind(kind), .char_code(char_code), .col(col), .row_sel(row_sel),
    .display_on(display_on), .cursor_on(cursor_on), .blink_on(blink_on),
    .backlight_on(backlight_on), .glyph_slot(glyph_slot), .glyph_rows(glyph_rows),
    .empty(empty), .pop(pop),
    .reg_select(reg_select), .enable_pin(enable_pin), .data_nibble(data_nibble),
    .backlight(backlight), .hold_us(hold_us), .last(last),
    .mismatches(mismatches), .words_pending(words_pending)
  );

  always #5 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    pop = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        pop <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_results = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic lcd_req_t make_req(input logic [2:0] k);
    lcd_req_t r;
    r.kind         = k;
    r.char_code    = 8'($urandom);
    r.col          = 6'($urandom);
    r.row_sel      = 2'($urandom);
    r.display_on   = 1'($urandom);
    r.cursor_on    = 1'($urandom);
    r.blink_on     = 1'($urandom);
    r.backlight_on = 1'($urandom);
    r.glyph_slot   = 3'($urandom);
    r.glyph_rows   = {$urandom, $urandom};
    return r;
  endfunction

  function automatic lcd_req_t random_req();
    int w;
    w = $urandom_range(0, 99);
    if (w < 3) return make_req(KIND_INIT);
    else if (w < 10) return make_req(KIND_CLEAR);
    else if (w < 22) return make_req(KIND_CONFIG);
    else if (w < 42) return make_req(KIND_GOTO);
    else if (w < 72) return make_req(KIND_CHAR);
    else if (w < 80) return make_req(KIND_GLYPH);
    else if (w < 92) return make_req(KIND_LIGHT);
    else return make_req(KIND_NONE);
  endfunction

  task automatic put(input lcd_req_t r);
    kind         <= r.kind;
    char_code    <= r.char_code;
    col          <= r.col;
    row_sel      <= r.row_sel;
    display_on   <= r.display_on;
    cursor_on    <= r.cursor_on;
    blink_on     <= r.blink_on;
    backlight_on <= r.backlight_on;
    glyph_slot   <= r.glyph_slot;
    glyph_rows   <= r.glyph_rows;
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic put_goto(input logic [1:0] row, input logic [5:0] column);
    lcd_req_t r;
    r = make_req(KIND_GOTO);
    r.row_sel = row;
    r.col     = column;
    put(r);
  endtask

  // ignored kinds never enter the input buffer; wait for all expected words, then a tail
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    lcd_req_t r;
    int       sent;
    cfg_we       = 1'b0;
    cfg_addr     = REG_ROW2_BASE;
    cfg_data     = 7'd0;
    push         = 1'b0;
    kind         = KIND_INIT;
    char_code    = 8'd0;
    col          = 6'd0;
    row_sel      = 2'd0;
    display_on   = 1'b0;
    cursor_on    = 1'b0;
    blink_on     = 1'b0;
    backlight_on = 1'b0;
    glyph_slot   = 3'd0;
    glyph_rows   = 64'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset row bases
    put(make_req(KIND_INIT));
    r = make_req(KIND_LIGHT); r.backlight_on = 1'b1; put(r);
    r = make_req(KIND_CHAR); r.char_code = 8'h00; put(r);
    r = make_req(KIND_CHAR); r.char_code = 8'hFF; put(r);
    r = make_req(KIND_CHAR); r.char_code = 8'h5A; put(r);
    put(make_req(KIND_CLEAR));
    r = make_req(KIND_CONFIG);
    r.display_on = 1'b1; r.cursor_on = 1'b1; r.blink_on = 1'b1; put(r);
    r = make_req(KIND_CONFIG);
    r.display_on = 1'b0; r.cursor_on = 1'b0; r.blink_on = 1'b0; put(r);
    put_goto(2'd0, 6'd0);
    put_goto(2'd1, 6'd63);
    put_goto(2'd2, 6'd19);
    put_goto(2'd3, 6'd20);
    r = make_req(KIND_GLYPH); r.glyph_slot = 3'd0; r.glyph_rows = '0; put(r);
    r = make_req(KIND_GLYPH); r.glyph_slot = 3'd7; r.glyph_rows = '1; put(r);
    put(make_req(KIND_NONE));
    put(make_req(KIND_INIT));
    r = make_req(KIND_LIGHT); r.backlight_on = 1'b0; put(r);

    // row base extremes, with address wrap
    drain();
    write_reg(REG_ROW2_BASE, 7'd0);
    write_reg(REG_ROW3_BASE, 7'd127);
    put_goto(2'd3, 6'd19);
    put_goto(2'd2, 6'd0);
    put_goto(2'd3, 6'd0);
    drain();
    write_reg(REG_ROW2_BASE, 7'd127);
    write_reg(REG_ROW3_BASE, 7'd0);
    put_goto(2'd2, 6'd63);
    put_goto(2'd3, 6'd39);

    for (int round = 0; round < 4; round++) begin
      drain();
      write_reg(REG_ROW2_BASE, 7'($urandom));
      write_reg(REG_ROW3_BASE, 7'($urandom));
      if (round == 1) hold_results = 1'b1;
      if (round == 3) quiet = 1'b1;
      sent = 0;
      while (sent < ROUND_ITEMS) begin
        r = random_req();
        put(r);
        if (r.kind != KIND_NONE) sent++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lcdseq_pkg.sv
rtl/core/lcdseq_queue.sv
rtl/core/lcdseq_front.sv
rtl/core/lcdseq_back.sv
rtl/core/char_lcd_4bit_command_sequencer_top.sv
bench/lcdseq_checker.sv
bench/char_lcd_4bit_command_sequencer_top_tb.sv
